@@ rtl/vtss_pkg.sv @@
// Shared types and constants for the valve time-slot sequencer.
package vtss_pkg;

    localparam int NUM_LEVEL_REGS = 6;
    localparam int VALVE_SLOTS    = 4;
    localparam int PCT_W          = 7;
    localparam int LT_W           = 28;
    localparam int PERIOD_W       = 16;
    localparam int SCALE_W        = 26;
    localparam int SCALE_FRAC     = 16;
    localparam int SUM_W          = 9;
    localparam int LEVEL_W        = 3;
    localparam int SLOT_W         = 2;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam int S_DATA_W       = 8;
    localparam int M_DATA_W       = 32;

    localparam logic [SUM_W-1:0]    PCT_FULL      = 9'd100;
    localparam logic [LT_W-1:0]     LT_RESET      = 28'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd1000;
    localparam logic [LEVEL_W-1:0]  LEVELS_RESET  = 3'd6;
    // Period scaled by 65536/100, rounded up, for a period of 1000 ticks.
    localparam logic [SCALE_W-1:0]  SCALE_RESET   = 26'd655360;
    localparam logic [9:0]          SCALE_INT     = 10'd655;
    localparam logic [4:0]          FRAC_NUM_MUL  = 5'd9;
    localparam logic [4:0]          FRAC_ROUND    = 5'd24;
    localparam logic [24:0]         REC25_MUL     = 25'd21474837;
    localparam int                  REC25_SHIFT   = 29;

    typedef enum logic [2:0] {
        REG_LT0    = 3'd0,
        REG_LT1    = 3'd1,
        REG_LT2    = 3'd2,
        REG_LT3    = 3'd3,
        REG_LT4    = 3'd4,
        REG_LT5    = 3'd5,
        REG_PERIOD = 3'd6,
        REG_LEVELS = 3'd7
    } vtss_reg_t;

    typedef struct packed {
        logic [NUM_LEVEL_REGS-1:0][LT_W-1:0] level_times;
        logic [SCALE_W-1:0]                  slot_scale;
        logic [LEVEL_W-1:0]                  level_count;
    } vtss_cfg_t;

endpackage

@@ rtl/vtss_regs.sv @@
// Configuration register bank with the APB port and the slot scale precomputation.
module vtss_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vtss_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [vtss_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vtss_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output vtss_pkg::vtss_cfg_t                 cfg
);

    logic [vtss_pkg::NUM_LEVEL_REGS-1:0][vtss_pkg::LT_W-1:0] level_times_reg;
    logic [vtss_pkg::PERIOD_W-1:0]                          period_reg;
    logic [vtss_pkg::SCALE_W-1:0]                           scale_reg;
    logic [vtss_pkg::SCALE_W-1:0]                           scale_next;
    logic [vtss_pkg::LEVEL_W-1:0]                           levels_reg;
    logic [vtss_pkg::PERIOD_W-1:0]                          wr_period;
    logic [19:0]                                            frac_num;
    logic [44:0]                                            frac_prod;
    logic                                                   wr_en;
    vtss_pkg::vtss_reg_t                                    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = vtss_pkg::vtss_reg_t'(paddr[4:2]);

    // The slot length is pct * period / 100; storing ceil(period * 65536 / 100) makes it
    // one multiplication and a shift at run time, exact for all 7-bit percentages.
    assign wr_period  = pwdata[vtss_pkg::PERIOD_W-1:0];
    assign frac_num   = 20'(wr_period) * 20'(vtss_pkg::FRAC_NUM_MUL)
                      + 20'(vtss_pkg::FRAC_ROUND);
    assign frac_prod  = 45'(frac_num) * 45'(vtss_pkg::REC25_MUL);
    assign scale_next = 26'(wr_period) * 26'(vtss_pkg::SCALE_INT)
                      + 26'(frac_prod[44:vtss_pkg::REC25_SHIFT]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vtss_pkg::NUM_LEVEL_REGS; i++) begin
                level_times_reg[i] <= vtss_pkg::LT_RESET;
            end
            period_reg <= vtss_pkg::PERIOD_RESET;
            scale_reg  <= vtss_pkg::SCALE_RESET;
            levels_reg <= vtss_pkg::LEVELS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                vtss_pkg::REG_LT0, vtss_pkg::REG_LT1, vtss_pkg::REG_LT2,
                vtss_pkg::REG_LT3, vtss_pkg::REG_LT4, vtss_pkg::REG_LT5: begin
                    level_times_reg[paddr[4:2]] <= pwdata[vtss_pkg::LT_W-1:0];
                end
                vtss_pkg::REG_PERIOD: begin
                    period_reg <= wr_period;
                    scale_reg  <= scale_next;
                end
                vtss_pkg::REG_LEVELS: begin
                    levels_reg <= pwdata[vtss_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            vtss_pkg::REG_LT0, vtss_pkg::REG_LT1, vtss_pkg::REG_LT2,
            vtss_pkg::REG_LT3, vtss_pkg::REG_LT4, vtss_pkg::REG_LT5: begin
                prdata = 32'(level_times_reg[paddr[4:2]]);
            end
            vtss_pkg::REG_PERIOD: prdata = 32'(period_reg);
            vtss_pkg::REG_LEVELS: prdata = 32'(levels_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.level_times = level_times_reg;
    assign cfg.slot_scale  = scale_reg;
    assign cfg.level_count = levels_reg;

endmodule

@@ rtl/vtss_core.sv @@
// Tick pipeline: input register, sequencer state update and result register.
module vtss_core #(
    parameter int NUM_VALVES = 4,
    parameter int MAX_LEVELS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  vtss_pkg::vtss_cfg_t               cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tick,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vtss_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam logic [vtss_pkg::SLOT_W-1:0]  SLOT_LAST  = vtss_pkg::SLOT_W'(NUM_VALVES - 1);
    localparam logic [vtss_pkg::LEVEL_W-1:0] LEVEL_LAST = vtss_pkg::LEVEL_W'(MAX_LEVELS - 1);
    localparam logic [vtss_pkg::LEVEL_W-1:0] LEVEL_MAX  = vtss_pkg::LEVEL_W'(MAX_LEVELS);

    logic                                   in_valid_reg;
    logic                                   tick_reg;
    logic                                   m_valid_reg;
    logic                                   adv;
    logic                                   fire;

    logic [vtss_pkg::VALVE_SLOTS-1:0]       valve_reg,    valve_next;
    logic [vtss_pkg::SLOT_W-1:0]            slot_reg,     slot_next;
    logic [vtss_pkg::LEVEL_W-1:0]           level_reg,    level_next;
    logic [vtss_pkg::PERIOD_W-1:0]          timer_reg,    timer_next;
    logic                                   in_cycle_reg, in_cycle_next;
    logic                                   stopped_reg,  stopped_next;
    logic                                   done_next;
    logic [vtss_pkg::M_DATA_W-1:0]          out_reg;

    logic                                   lvl_ok;
    logic [vtss_pkg::LT_W-1:0]              lt_sel;
    logic [vtss_pkg::VALVE_SLOTS-1:0][vtss_pkg::PCT_W-1:0] pct;
    logic [vtss_pkg::SUM_W-1:0]             pct_sum;
    logic [vtss_pkg::PCT_W-1:0]             pct_cur;
    logic [32:0]                            len_prod;
    logic [16:0]                            len_raw;
    logic [vtss_pkg::PERIOD_W-1:0]          slot_len;
    logic [vtss_pkg::LEVEL_W-1:0]           level_last;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign fire     = in_valid_reg && adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    assign lvl_ok = (level_reg < LEVEL_MAX)
                 && (level_reg < vtss_pkg::LEVEL_W'(vtss_pkg::NUM_LEVEL_REGS));
    assign lt_sel = lvl_ok ? cfg.level_times[level_reg] : '0;

    always_comb begin
        pct_sum = '0;
        for (int v = 0; v < vtss_pkg::VALVE_SLOTS; v++) begin
            pct[v]  = (v < NUM_VALVES) ? lt_sel[v*vtss_pkg::PCT_W +: vtss_pkg::PCT_W] : '0;
            pct_sum = pct_sum + vtss_pkg::SUM_W'(pct[v]);
        end
    end

    assign pct_cur  = pct[slot_reg];
    assign len_prod = 33'(pct_cur) * 33'(cfg.slot_scale);
    assign len_raw  = len_prod[32:vtss_pkg::SCALE_FRAC];

    always_comb begin
        if (len_raw == '0) begin
            slot_len = vtss_pkg::PERIOD_W'(1);
        end else if (len_raw[16]) begin
            slot_len = '1;
        end else begin
            slot_len = len_raw[vtss_pkg::PERIOD_W-1:0];
        end
    end

    always_comb begin
        if (cfg.level_count == '0) begin
            level_last = '0;
        end else if (cfg.level_count > LEVEL_MAX) begin
            level_last = LEVEL_LAST;
        end else begin
            level_last = cfg.level_count - vtss_pkg::LEVEL_W'(1);
        end
    end

    always_comb begin
        logic                          ok;
        logic                          slot_end;
        logic [vtss_pkg::PERIOD_W-1:0] timer_cur;

        ok            = 1'b1;
        slot_end      = 1'b0;
        timer_cur     = timer_reg;
        valve_next    = valve_reg;
        slot_next     = slot_reg;
        level_next    = level_reg;
        timer_next    = timer_reg;
        in_cycle_next = in_cycle_reg;
        stopped_next  = stopped_reg;
        done_next     = 1'b0;

        if (tick_reg && !stopped_reg) begin
            if (!in_cycle_reg) begin
                if (pct_sum != vtss_pkg::PCT_FULL) begin
                    stopped_next = 1'b1;
                    valve_next   = '0;
                    ok           = 1'b0;
                end else begin
                    in_cycle_next = 1'b1;
                end
            end

            if (ok) begin
                if (pct_cur == '0) begin
                    timer_next = '0;
                    slot_end   = 1'b1;
                end else begin
                    if (timer_reg == '0) begin
                        timer_cur  = slot_len;
                        valve_next = vtss_pkg::VALVE_SLOTS'(1) << slot_reg;
                    end
                    timer_next = timer_cur - vtss_pkg::PERIOD_W'(1);
                    slot_end   = (timer_cur == vtss_pkg::PERIOD_W'(1));
                end

                if (slot_end) begin
                    if (slot_reg >= SLOT_LAST) begin
                        slot_next     = '0;
                        in_cycle_next = 1'b0;
                        done_next     = 1'b1;
                        level_next    = (level_reg >= level_last) ? '0
                                      : level_reg + vtss_pkg::LEVEL_W'(1);
                    end else begin
                        slot_next = slot_reg + vtss_pkg::SLOT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            valve_reg    <= '0;
            slot_reg     <= '0;
            level_reg    <= '0;
            timer_reg    <= '0;
            in_cycle_reg <= 1'b0;
            stopped_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                m_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                valve_reg    <= valve_next;
                slot_reg     <= slot_next;
                level_reg    <= level_next;
                timer_reg    <= timer_next;
                in_cycle_reg <= in_cycle_next;
                stopped_reg  <= stopped_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg <= s_tick;
        end
        if (fire) begin
            out_reg <= {5'b0, done_next, stopped_next, timer_next, level_next,
                        slot_next, valve_next};
        end
    end

`ifndef NO_ASSERTIONS
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("Halt was released without a reset.");

    a_halt_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> (valve_reg == '0))
        else $error("A valve is open while halted.");

    a_one_valve: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(valve_reg))
        else $error("More than one valve is open.");

    a_done_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg[26]) |-> (out_reg[5:4] == '0 && !out_reg[25]))
        else $error("Cycle end reported without the slot wrapping.");
`endif

endmodule

@@ rtl/valve_time_slot_sequencer.sv @@
// Top level of the valve time-slot sequencer.
//
// The input stream carries one item per loop tick: s_tdata bit 0 set means a
// tick elapses, clear means the state is held. Each accepted item gives
// exactly one result item on the output stream with the state after that
// tick: the open valve mask, the running slot, the heat level, the ticks left
// in the slot, the halt flag and a flag on the tick that ends a full cycle.
// A result passes the input register and then the result register after its
// item is accepted, and one item is taken in every cycle while the receiver
// keeps m_tready high; the slot length comes from one multiplication of the
// percentage by a scaled period that is prepared when the period register is written.
// When the receiver stalls, the result register holds its item and one
// further item waits in the input register; s_tready falls only then.
// Reset clears the sequencer (all valves closed, level and slot zero, not
// halted) and loads the register defaults. Registers must be written through
// the APB port only while no item is in flight; the block does not enforce it.
module valve_time_slot_sequencer #(
    parameter int NUM_VALVES = 4,
    parameter int MAX_LEVELS = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vtss_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [vtss_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vtss_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [vtss_pkg::S_DATA_W-1:0]       s_tdata,  // [0] tick
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] valve_mask, [5:4] active_valve, [8:6] active_level,
    // [24:9] ticks_left, [25] halted, [26] cycle_done
    output logic [vtss_pkg::M_DATA_W-1:0]       m_tdata
);

    vtss_pkg::vtss_cfg_t cfg;

    vtss_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vtss_core #(
        .NUM_VALVES (NUM_VALVES),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tick   (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
